FILE: hdl/tpt_pkg.sv
`default_nettype none
package tpt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_CR1,
    ST_CR2,
    ST_OFFX,
    ST_OFFY,
    ST_BUILD,
    ST_EMIT
  } tpt_state_t;

  localparam logic [11:0] HW_RESET   = 12'd160;
  localparam logic [1:0]  PH_FIRST   = 2'd0;
  localparam logic [1:0]  PH_SECOND  = 2'd1;
  localparam logic [1:0]  PH_CONT    = 2'd2;
  localparam logic [2:0]  SLOT_LAST  = 3'd5;
  localparam logic [4:0]  SQRT_STEPS = 5'd31;
  localparam logic [4:0]  DIV_STEPS  = 5'd15;

endpackage
`default_nettype wire

FILE: hdl/thick_polyline_tessellator_top.sv
`default_nettype none
// Thick polyline stroke tessellator.
// Points enter on the in_ channel (in_valid / in_stall). The first point of a
// polyline, or any point with in_start_new set, is simply stored and
// produces nothing. Every later point produces six vertices of two triangles
// on the out_ channel, slots 0 to 5, with out_last_vertex on slot 5.
// Each joined point runs through one sequencer: two squaring steps, a 32-step
// square root, two 16-step divisions for the unit normal, two cross-product
// steps when joining, two offset steps and one build step. The root and the
// two divisions share one 64-bit subtractor; products share one 18x18
// multiplier.
// in_stall is high while a point is being worked on or its vertices are
// being sent. When the receiver raises out_stall the current vertex holds
// and the block waits. Reset restores half width 160 (10 pixels) and waits for
// the first point of a new polyline. cfg_we writes the half width.
module thick_polyline_tessellator_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire        [11:0] cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] in_point_x,
  input  wire signed [15:0] in_point_y,
  input  wire               in_start_new,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_vertex_x,
  output logic signed [15:0] out_vertex_y,
  output logic        [2:0] out_vertex_slot,
  output logic              out_last_vertex
);

  tpt_pkg::tpt_state_t state_r, state_nxt;

  logic [11:0] hw_r;
  logic [1:0]  phase_r;
  logic        cont_r;
  logic signed [15:0] sx_r, sy_r, bx_r, by_r;
  logic signed [15:0] h0x_r, h0y_r, h1x_r, h1y_r, h2x_r, h2y_r;
  logic signed [16:0] abx_r, aby_r, zax_r, zay_r;
  logic signed [35:0] sq_r, cr_r;
  logic [63:0] n_r, res_r;
  logic [30:0] len_r;
  logic [45:0] rem_r;
  logic [14:0] q_r, umx_r, umy_r;
  logic [4:0]  k_r;
  logic signed [14:0] o1x_r, o1y_r, o2x_r, o2y_r;
  logic signed [15:0] a0x_r, a0y_r, a1x_r, a1y_r, b0x_r, b0y_r, b1x_r, b1y_r;
  logic [2:0]  slot_r;

  logic in_acc, out_acc, new_line;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign new_line = in_start_new || (phase_r == tpt_pkg::PH_FIRST);

  // Shared subtractor for the square root and both divisions.
  logic [63:0] sub_a, sub_b, sq_bit, sq_res_new;
  logic [64:0] sub_d;
  logic        sub_ge;
  assign sq_bit = 64'd1 << {k_r, 1'b0};
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      tpt_pkg::ST_SQRT: begin
        sub_a = n_r;
        sub_b = res_r | sq_bit;
      end
      tpt_pkg::ST_DIVX, tpt_pkg::ST_DIVY: begin
        sub_a = {18'd0, rem_r};
        sub_b = {33'd0, len_r} << k_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end
  assign sub_d      = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge     = !sub_d[64];
  assign sq_res_new = (res_r >> 1) + (sub_ge ? sq_bit : 64'd0);

  // Shared multiplier.
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  always_comb begin
    case (state_r)
      tpt_pkg::ST_SQ1: begin
        mul_a = {abx_r[16], abx_r};
        mul_b = {abx_r[16], abx_r};
      end
      tpt_pkg::ST_SQ2: begin
        mul_a = {aby_r[16], aby_r};
        mul_b = {aby_r[16], aby_r};
      end
      tpt_pkg::ST_CR1: begin
        mul_a = {zax_r[16], zax_r};
        mul_b = {aby_r[16], aby_r};
      end
      tpt_pkg::ST_CR2: begin
        mul_a = {zay_r[16], zay_r};
        mul_b = {abx_r[16], abx_r};
      end
      tpt_pkg::ST_OFFX: begin
        mul_a = {3'd0, umx_r};
        mul_b = {6'd0, hw_r};
      end
      tpt_pkg::ST_OFFY: begin
        mul_a = {3'd0, umy_r};
        mul_b = {6'd0, hw_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Offsets from the product: half width and full width, rounded.
  logic [27:0] o1_sum, o2_sum;
  logic [13:0] o1m, o2m;
  assign o1_sum = {1'b0, mul_p[26:0]} + 28'd8192;
  assign o2_sum = {mul_p[26:0], 1'b0} + 28'd8192;
  assign o1m    = o1_sum[27:14];
  assign o2m    = o2_sum[27:14];

  // Quotient of the current division, clamped to one in Q1.14.
  logic [15:0] q_full;
  logic [14:0] q_clamp;
  assign q_full  = {q_r, sub_ge};
  assign q_clamp = (len_r == '0) ? 15'd0 :
                   (q_full > 16'd16384) ? 15'd16384 : q_full[14:0];

  // Magnitudes of the normal components.
  logic [16:0] mx, my;
  assign mx = aby_r[16] ? 17'(-aby_r) : 17'(aby_r);
  assign my = abx_r[16] ? 17'(-abx_r) : 17'(abx_r);

  // Segment vector from the incoming point.
  logic signed [16:0] msx, msy, abx_in, aby_in;
  always_comb begin
    msx = {h0x_r[15], h0x_r} + {h1x_r[15], h1x_r};
    msy = {h0y_r[15], h0y_r} + {h1y_r[15], h1y_r};
    if (phase_r == tpt_pkg::PH_SECOND) begin
      abx_in = {in_point_x[15], in_point_x} - {sx_r[15], sx_r};
      aby_in = {in_point_y[15], in_point_y} - {sy_r[15], sy_r};
    end else begin
      abx_in = {in_point_x[15], in_point_x} - {msx[16], msx[16:1]};
      aby_in = {in_point_y[15], in_point_y} - {msy[16], msy[16:1]};
    end
  end

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] p,
                                                 input logic signed [14:0] o);
    logic signed [16:0] s;
    s = {p[15], p} + {{2{o[14]}}, o};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  logic cr_pos;
  assign cr_pos = !cr_r[35] && (cr_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpt_pkg::ST_IDLE: begin
        if (in_acc && !new_line) state_nxt = tpt_pkg::ST_SQ1;
      end
      tpt_pkg::ST_SQ1: state_nxt = tpt_pkg::ST_SQ2;
      tpt_pkg::ST_SQ2: state_nxt = tpt_pkg::ST_SQRT;
      tpt_pkg::ST_SQRT: begin
        if (k_r == '0) state_nxt = tpt_pkg::ST_DIVX;
      end
      tpt_pkg::ST_DIVX: begin
        if (k_r == '0) state_nxt = tpt_pkg::ST_DIVY;
      end
      tpt_pkg::ST_DIVY: begin
        if (k_r == '0) state_nxt = cont_r ? tpt_pkg::ST_CR1 : tpt_pkg::ST_OFFX;
      end
      tpt_pkg::ST_CR1:   state_nxt = tpt_pkg::ST_CR2;
      tpt_pkg::ST_CR2:   state_nxt = tpt_pkg::ST_OFFX;
      tpt_pkg::ST_OFFX:  state_nxt = tpt_pkg::ST_OFFY;
      tpt_pkg::ST_OFFY:  state_nxt = tpt_pkg::ST_BUILD;
      tpt_pkg::ST_BUILD: state_nxt = tpt_pkg::ST_EMIT;
      tpt_pkg::ST_EMIT: begin
        if (out_acc && slot_r == tpt_pkg::SLOT_LAST) state_nxt = tpt_pkg::ST_IDLE;
      end
      default: state_nxt = tpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != tpt_pkg::ST_IDLE);
    out_valid = (state_r == tpt_pkg::ST_EMIT);
  end

  always_comb begin
    case (slot_r)
      3'd0: begin
        out_vertex_x = a0x_r;
        out_vertex_y = a0y_r;
      end
      3'd1: begin
        out_vertex_x = a1x_r;
        out_vertex_y = a1y_r;
      end
      3'd3: begin
        out_vertex_x = cont_r ? a0x_r : a1x_r;
        out_vertex_y = cont_r ? a0y_r : a1y_r;
      end
      3'd5: begin
        out_vertex_x = b1x_r;
        out_vertex_y = b1y_r;
      end
      default: begin
        out_vertex_x = b0x_r;
        out_vertex_y = b0y_r;
      end
    endcase
  end
  assign out_vertex_slot = slot_r;
  assign out_last_vertex = (slot_r == tpt_pkg::SLOT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpt_pkg::ST_IDLE;
      hw_r    <= tpt_pkg::HW_RESET;
      phase_r <= tpt_pkg::PH_FIRST;
      sx_r    <= '0;
      sy_r    <= '0;
      h0x_r   <= '0;
      h0y_r   <= '0;
      h1x_r   <= '0;
      h1y_r   <= '0;
      h2x_r   <= '0;
      h2y_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) hw_r <= cfg_wdata;
      case (state_r)
        tpt_pkg::ST_IDLE: begin
          if (in_acc) begin
            bx_r <= in_point_x;
            by_r <= in_point_y;
            if (new_line) begin
              sx_r    <= in_point_x;
              sy_r    <= in_point_y;
              phase_r <= tpt_pkg::PH_SECOND;
            end else begin
              cont_r <= (phase_r != tpt_pkg::PH_SECOND);
              abx_r  <= abx_in;
              aby_r  <= aby_in;
              zax_r  <= {h0x_r[15], h0x_r} - {h2x_r[15], h2x_r};
              zay_r  <= {h0y_r[15], h0y_r} - {h2y_r[15], h2y_r};
            end
          end
        end
        tpt_pkg::ST_SQ1: sq_r <= mul_p;
        tpt_pkg::ST_SQ2: begin
          n_r   <= {30'd0, 34'(sq_r + mul_p)} << 28;
          res_r <= '0;
          k_r   <= tpt_pkg::SQRT_STEPS;
        end
        tpt_pkg::ST_SQRT: begin
          res_r <= sq_res_new;
          if (sub_ge) n_r <= sub_d[63:0];
          k_r <= k_r - 5'd1;
          if (k_r == '0) begin
            len_r <= sq_res_new[30:0];
            rem_r <= ({29'd0, mx} << 28) + {16'd0, sq_res_new[30:1]};
            q_r   <= '0;
            k_r   <= tpt_pkg::DIV_STEPS;
          end
        end
        tpt_pkg::ST_DIVX, tpt_pkg::ST_DIVY: begin
          if (sub_ge) rem_r <= sub_d[45:0];
          q_r <= {q_r[13:0], sub_ge};
          k_r <= k_r - 5'd1;
          if (k_r == '0) begin
            if (state_r == tpt_pkg::ST_DIVX) begin
              umx_r <= q_clamp;
              rem_r <= ({29'd0, my} << 28) + {16'd0, len_r[30:1]};
              q_r   <= '0;
              k_r   <= tpt_pkg::DIV_STEPS;
            end else begin
              umy_r <= q_clamp;
            end
          end
        end
        tpt_pkg::ST_CR1: cr_r <= mul_p;
        tpt_pkg::ST_CR2: cr_r <= cr_r - mul_p;
        tpt_pkg::ST_OFFX: begin
          // The x normal follows the sign of ab.y.
          o1x_r <= aby_r[16] ? -$signed({1'b0, o1m}) : $signed({1'b0, o1m});
          o2x_r <= aby_r[16] ? -$signed({1'b0, o2m}) : $signed({1'b0, o2m});
        end
        tpt_pkg::ST_OFFY: begin
          // The y normal is negative when ab.x is positive.
          if (!abx_r[16] && abx_r != '0) begin
            o1y_r <= -$signed({1'b0, o1m});
            o2y_r <= -$signed({1'b0, o2m});
          end else begin
            o1y_r <= $signed({1'b0, o1m});
            o2y_r <= $signed({1'b0, o2m});
          end
        end
        tpt_pkg::ST_BUILD: begin
          b0x_r <= sat_add(bx_r, o1x_r);
          b0y_r <= sat_add(by_r, o1y_r);
          b1x_r <= sat_add(bx_r, -o1x_r);
          b1y_r <= sat_add(by_r, -o1y_r);
          h0x_r <= sat_add(bx_r, -o1x_r);
          h0y_r <= sat_add(by_r, -o1y_r);
          h1x_r <= sat_add(bx_r, o1x_r);
          h1y_r <= sat_add(by_r, o1y_r);
          slot_r  <= '0;
          phase_r <= tpt_pkg::PH_CONT;
          if (!cont_r) begin
            a0x_r <= sat_add(sx_r, o1x_r);
            a0y_r <= sat_add(sy_r, o1y_r);
            a1x_r <= sat_add(sx_r, -o1x_r);
            a1y_r <= sat_add(sy_r, -o1y_r);
            h2x_r <= sat_add(sx_r, -o1x_r);
            h2y_r <= sat_add(sy_r, -o1y_r);
          end else if (cr_pos) begin
            // Turning one way keeps the second-last corner.
            a0x_r <= sat_add(h1x_r, -o2x_r);
            a0y_r <= sat_add(h1y_r, -o2y_r);
            a1x_r <= h1x_r;
            a1y_r <= h1y_r;
            h2x_r <= sat_add(h1x_r, -o2x_r);
            h2y_r <= sat_add(h1y_r, -o2y_r);
          end else begin
            a0x_r <= h0x_r;
            a0y_r <= h0y_r;
            a1x_r <= sat_add(h0x_r, o2x_r);
            a1y_r <= sat_add(h0y_r, o2y_r);
            h2x_r <= h0x_r;
            h2y_r <= h0y_r;
          end
        end
        tpt_pkg::ST_EMIT: begin
          if (out_acc) slot_r <= slot_r + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tpt_checker.sv
`default_nettype none
module tpt_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] out_vertex_x,
  input wire signed [15:0] out_vertex_y,
  input wire        [2:0]  out_vertex_slot,
  input wire               out_last_vertex
);

  // No new point is taken while vertices are still going out.
  a_busy_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("point accepted while vertices pending");

  // Slots advance by one within a group.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_vertex |=>
      out_valid && (out_vertex_slot == $past(out_vertex_slot) + 3'd1))
    else $error("vertex slot did not advance");

  // A group ends after its last vertex.
  a_group_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_vertex |=> !out_valid)
    else $error("vertex after end of group");

  // A stalled vertex holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_x) &&
      $stable(out_vertex_y) && $stable(out_vertex_slot))
    else $error("stalled vertex changed");

endmodule

bind thick_polyline_tessellator_top tpt_checker u_tpt_checker (.*);
`default_nettype wire

FILE: verif/tpt_stroke_checker.sv
`timescale 1ns / 100ps
module tpt_stroke_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire        [11:0] cfg_wdata,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [15:0] in_point_x,
  input  wire signed [15:0] in_point_y,
  input  wire               in_start_new,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [15:0] out_vertex_x,
  input  wire signed [15:0] out_vertex_y,
  input  wire        [2:0]  out_vertex_slot,
  input  wire               out_last_vertex,
  output int                pending_vertices,
  output int                vertices_checked,
  output int                mismatch_count
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         slot;
    logic               last;
  } stroke_vertex_t;

  stroke_vertex_t vertex_q[$];

  logic [11:0] half_w;
  logic [1:0]  stroke_phase;
  longint      anchor_x, anchor_y;
  longint      recent_x[3], recent_y[3];

  assign pending_vertices = vertex_q.size();

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint c, longint unsigned len);
    longint unsigned m, q;
    m = (c < 0) ? -c : c;
    q = ((m << 28) + len / 2) / len;
    if (q > 16384) q = 16384;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round14(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + 8192) >> 14;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Offsets of one and two half widths along the unit normal (dy, -dx).
  task automatic stroke_offsets(input longint dx, input longint dy,
                                output longint h1x, output longint h1y,
                                output longint h2x, output longint h2y);
    longint nx, ny, ux, uy;
    longint unsigned len;
    nx = dy;
    ny = -dx;
    len = root64(longint'(nx * nx + ny * ny) << 28);
    ux = 0;
    uy = 0;
    if (len != 0) begin
      ux = unit_part(nx, len);
      uy = unit_part(ny, len);
    end
    h1x = round14(ux * half_w);
    h1y = round14(uy * half_w);
    h2x = round14(ux * 2 * half_w);
    h2y = round14(uy * 2 * half_w);
  endtask

  task automatic predict_point(input longint bx, input longint by, input logic fresh);
    longint h1x, h1y, h2x, h2y, dx, dy, cr;
    longint a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
    longint vx[6], vy[6];
    stroke_vertex_t v;
    if (fresh || stroke_phase == tpt_pkg::PH_FIRST) begin
      anchor_x = bx;
      anchor_y = by;
      stroke_phase = tpt_pkg::PH_SECOND;
      return;
    end
    if (stroke_phase == tpt_pkg::PH_SECOND) begin
      stroke_offsets(bx - anchor_x, by - anchor_y, h1x, h1y, h2x, h2y);
      a0x = sat16(anchor_x + h1x);
      a0y = sat16(anchor_y + h1y);
      a1x = sat16(anchor_x - h1x);
      a1y = sat16(anchor_y - h1y);
      b0x = sat16(bx + h1x);
      b0y = sat16(by + h1y);
      b1x = sat16(bx - h1x);
      b1y = sat16(by - h1y);
      vx = '{a0x, a1x, b0x, a1x, b0x, b1x};
      vy = '{a0y, a1y, b0y, a1y, b0y, b1y};
      stroke_phase = tpt_pkg::PH_CONT;
    end else begin
      a0x = recent_x[0];
      a0y = recent_y[0];
      a1x = recent_x[1];
      a1y = recent_y[1];
      dx = bx - ((a0x + a1x) >>> 1);
      dy = by - ((a0y + a1y) >>> 1);
      stroke_offsets(dx, dy, h1x, h1y, h2x, h2y);
      b0x = sat16(bx + h1x);
      b0y = sat16(by + h1y);
      b1x = sat16(bx - h1x);
      b1y = sat16(by - h1y);
      // Turn direction picks which old corner stays put.
      cr = (a0x - recent_x[2]) * dy - (a0y - recent_y[2]) * dx;
      if (cr > 0) begin
        a0x = sat16(a1x - h2x);
        a0y = sat16(a1y - h2y);
      end else begin
        a1x = sat16(a0x + h2x);
        a1y = sat16(a0y + h2y);
      end
      vx = '{a0x, a1x, b0x, a0x, b0x, b1x};
      vy = '{a0y, a1y, b0y, a0y, b0y, b1y};
    end
    for (int k = 0; k < 6; k++) begin
      v.x = vx[k][15:0];
      v.y = vy[k][15:0];
      v.slot = k[2:0];
      v.last = (k[2:0] == tpt_pkg::SLOT_LAST);
      vertex_q.push_back(v);
    end
    recent_x = '{vx[5], vx[4], vx[3]};
    recent_y = '{vy[5], vy[4], vy[3]};
  endtask

  always @(posedge clk) begin
    stroke_vertex_t want;
    if (!rst_n) begin
      half_w <= tpt_pkg::HW_RESET;
      stroke_phase = tpt_pkg::PH_FIRST;
      anchor_x = 0;
      anchor_y = 0;
      recent_x = '{0, 0, 0};
      recent_y = '{0, 0, 0};
      vertex_q.delete();
      vertices_checked <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_we) half_w <= cfg_wdata;
      if (in_valid && !in_stall) predict_point(in_point_x, in_point_y, in_start_new);
      if (out_valid && !out_stall) begin
        vertices_checked <= vertices_checked + 1;
        if (vertex_q.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected vertex x=%0d y=%0d slot=%0d",
                                            out_vertex_x, out_vertex_y, out_vertex_slot);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = vertex_q.pop_front();
          if (out_vertex_x !== want.x || out_vertex_y !== want.y ||
              out_vertex_slot !== want.slot || out_last_vertex !== want.last) begin
            if (mismatch_count < 10)
              $display({"vertex mismatch: expected x=%0d y=%0d slot=%0d last=%0b,",
                        " got x=%0d y=%0d slot=%0d last=%0b"},
                       want.x, want.y, want.slot, want.last,
                       out_vertex_x, out_vertex_y, out_vertex_slot, out_last_vertex);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/thick_polyline_tessellator_top_tb.sv
`timescale 1ns / 100ps
module thick_polyline_tessellator_top_tb;

  localparam int IDLE_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic        [11:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic               in_start_new = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_vertex_x;
  logic signed [15:0] out_vertex_y;
  logic        [2:0]  out_vertex_slot;
  logic               out_last_vertex;

  int pending_vertices, vertices_checked, mismatch_count;
  int points_sent, burst_left, idle_cycles, stall_left, calm_left;
  logic stall_now;

  always #5 clk = ~clk;

  thick_polyline_tessellator_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_start_new(in_start_new),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y), .out_vertex_slot(out_vertex_slot),
    .out_last_vertex(out_last_vertex)
  );

  tpt_stroke_checker stroke_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_start_new(in_start_new),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y), .out_vertex_slot(out_vertex_slot),
    .out_last_vertex(out_last_vertex), .pending_vertices(pending_vertices),
    .vertices_checked(vertices_checked), .mismatch_count(mismatch_count)
  );

  // Receiver stalls in runs, with calm stretches where it never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      calm_left <= 0;
      stall_now <= 1'b0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= stall_now;
    end else begin
      stall_left <= $urandom_range(1, 12);
      stall_now <= calm_left > 0 ? 1'b0 : ($urandom_range(0, 2) == 0);
      calm_left <= calm_left > 0 ? calm_left - 1 : ($urandom_range(0, 9) == 0 ? 20 : 0);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[thick_polyline_tessellator_top] ERROR");
        $finish;
      end
    end
  end

  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input logic fresh);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_point_x <= px;
    in_point_y <= py;
    in_start_new <= fresh;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_vertices != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_half_width(input logic [11:0] hw);
    drain_requests();
    cfg_we <= 1'b1;
    cfg_wdata <= hw;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random polyline: mostly short hops, sometimes anywhere in the plane.
  task automatic random_polyline(input int len);
    logic signed [15:0] px, py;
    px = 16'($urandom);
    py = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        px = 16'($urandom);
        py = 16'($urandom);
      end else if ($urandom_range(0, 15) != 0) begin
        px = px + $signed(16'($urandom_range(0, 1023)) - 16'sd512);
        py = py + $signed(16'($urandom_range(0, 1023)) - 16'sd512);
      end
      send_point(px, py, i == 0 || $urandom_range(0, 40) == 0);
    end
  endtask

  initial begin
    burst_left = 0;
    points_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width: first point without start_new, turning joins and a repeated point.
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd160, 16'sd0, 1'b0);
    send_point(16'sd320, 16'sd160, 1'b0);
    send_point(16'sd480, -16'sd160, 1'b0);
    send_point(16'sd480, -16'sd160, 1'b0);
    send_point(16'sd640, -16'sd160, 1'b0);
    // Zero-length first segment.
    send_point(16'sd50, 16'sd50, 1'b1);
    send_point(16'sd50, 16'sd50, 1'b0);
    // Full-range corners drive the outputs into saturation.
    send_point(-16'sd32768, -16'sd32768, 1'b1);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    set_half_width(12'd4095);
    send_point(16'sd32767, 16'sd0, 1'b1);
    send_point(-16'sd32768, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd32767, 1'b0);
    send_point(16'sd100, -16'sd100, 1'b1);
    send_point(16'sd101, -16'sd100, 1'b0);
    set_half_width(12'd0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd300, 16'sd300, 1'b0);
    send_point(-16'sd300, 16'sd300, 1'b0);

    for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
      case (phase_idx)
        0: set_half_width(12'd1);
        1: set_half_width(12'd160);
        2: set_half_width(12'd4095);
        default: set_half_width(12'($urandom_range(0, 4095)));
      endcase
      while (points_sent < 20 + (phase_idx + 1) * 67) begin
        random_polyline($urandom_range(2, 9));
        if ($urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          burst_left = 0;
          @(posedge clk);
          while (pending_vertices != 0) @(posedge clk);
        end
      end
    end

    drain_requests();
    $display("Sent %0d points over several half widths (0, 1, 160, 4095, random);",
             points_sent);
    $display("checked %0d stroke vertices under random sender gaps and receiver stalls.",
             vertices_checked);
    if (mismatch_count == 0 && pending_vertices == 0) begin
      $display("[thick_polyline_tessellator_top] OK");
    end else begin
      $display("[thick_polyline_tessellator_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tpt_pkg.sv
hdl/thick_polyline_tessellator_top.sv
hdl/tpt_checker.sv
verif/tpt_stroke_checker.sv
verif/thick_polyline_tessellator_top_tb.sv
